[sv/assert_macros.svh]
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

[sv/sdff_pkg.sv]
// ----------------------------------------------------------------------------
// sdff_pkg
// shared types, constants and digit tables for the display frame formatter
// ----------------------------------------------------------------------------
package sdff_pkg;

   localparam int RAM_BYTES = 14;
   localparam int ADDR_W = 4;

   localparam logic [3:0] FUNC_INIT   = 4'd0;
   localparam logic [3:0] FUNC_CLEAR  = 4'd1;
   localparam logic [3:0] FUNC_ALLON  = 4'd2;
   localparam logic [3:0] FUNC_DIGON  = 4'd3;
   localparam logic [3:0] FUNC_DEFLT  = 4'd4;
   localparam logic [3:0] FUNC_AP     = 4'd5;
   localparam logic [3:0] FUNC_LEDS   = 4'd6;
   localparam logic [3:0] FUNC_SPEED  = 4'd7;
   localparam logic [3:0] FUNC_TIMER  = 4'd8;
   localparam logic [3:0] FUNC_PM25   = 4'd9;
   localparam logic [3:0] FUNC_FILTER = 4'd10;
   localparam logic [3:0] FUNC_BRIGHT = 4'd11;
   localparam logic [3:0] FUNC_RAW    = 4'd12;

   localparam logic [7:0] CMD_WRITE = 8'h44;
   localparam logic [7:0] CMD_ADDR  = 8'hC0;
   localparam logic [7:0] CMD_MODE  = 8'h03;
   localparam logic [7:0] CMD_AUTO  = 8'h40;
   localparam logic [7:0] CMD_ON    = 8'h8F;

   // op kinds for a single byte write
   typedef enum logic [2:0] {
      OP_SET,      // byte = data
      OP_OR,       // byte = shadow | data
      OP_AND,      // byte = shadow & data
      OP_LOW,      // digit low byte: (shadow & 1) | data
      OP_LED       // shadow bit 0 replaced by data[0]
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_READ,
      ST_CMD,
      ST_DATA,
      ST_SOLO
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;     // capture the request
      logic       prep;     // compute the byte for step
      logic [4:0] step;
      logic       commit;   // write shadow
      logic       clear;    // reset-time clearing pass
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [4:0] nsteps;   // number of byte writes
      logic       has_pre;  // init prefix frames
      logic       solo;     // single command frame only
      logic       none;     // no frames
   } dp_stat_type;

   function automatic logic [7:0] seg_low(input logic [3:0] d);
      logic [7:0] r;
      case (d)
         4'd0: r = 8'h6E;
         4'd1: r = 8'h60;
         4'd2: r = 8'h56;
         4'd3: r = 8'h72;
         4'd4: r = 8'h78;
         4'd5: r = 8'h3A;
         4'd6: r = 8'h3E;
         4'd7: r = 8'h60;
         4'd8: r = 8'h7E;
         4'd9: r = 8'h7A;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

[sv/sdff_if.sv]
// ----------------------------------------------------------------------------
// sdff_req_if / sdff_rsp_if
// valid/ready channels for requests and frames
// ----------------------------------------------------------------------------
interface sdff_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] func;
   logic [15:0] value;
   logic [3:0] addr;
   logic [7:0] data;
   modport source (output valid, func, value, addr, data, input ready);
   modport sink (input valid, func, value, addr, data, output ready);
endinterface

interface sdff_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_cmd;
   logic       has_data;
   logic [7:0] frame_data;
   logic       last;
   modport source (output valid, frame_cmd, has_data, frame_data, last, input ready);
   modport sink (input valid, frame_cmd, has_data, frame_data, last, output ready);
endinterface

[sv/segment_display_frame_formatter_core.sv]
// ----------------------------------------------------------------------------
// segment_display_frame_formatter_core
// turns display requests into controller command/data frames
// ----------------------------------------------------------------------------
// One request at a time. Each byte write passes through a shadow read, a
// command frame and an address/data frame, after the request is accepted
// and planned; init sends 31 frames. The shadow ram is cleared during reset.
`include "assert_macros.svh"

module segment_display_frame_formatter_core (
   input logic         clock,
   input logic         reset,
   sdff_req_if.sink    req,
   sdff_rsp_if.source  rsp
);

   sdff_pkg::dp_cmd_type  cmd;
   sdff_pkg::dp_stat_type stat;
   logic [3:0] wr_addr;
   logic [7:0] wr_byte;

   sdff_datapath u_dp (
      .clock(clock), .func(req.func), .value(req.value), .addr(req.addr),
      .data(req.data), .cmd(cmd), .stat(stat), .wr_addr(wr_addr), .wr_byte(wr_byte)
   );

   sdff_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_value(req.value), .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_cmd(rsp.frame_cmd), .out_has(rsp.has_data), .out_data(rsp.frame_data),
      .out_last(rsp.last), .stat(stat), .cmd(cmd), .wr_addr(wr_addr), .wr_byte(wr_byte)
   );

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp.valid, !req.ready)
   `ASSERT_IMPL(a_data_zero, clock, reset, rsp.valid && !rsp.has_data,
                rsp.frame_data == 8'h00)
   `ASSERT_NEXT(a_last_idle, clock, reset, rsp.valid && rsp.ready && rsp.last,
                !rsp.valid)

endmodule

[sv/sdff_datapath.sv]
// ----------------------------------------------------------------------------
// sdff_datapath
// request registers, digit split, shadow ram and per-step byte generation
// ----------------------------------------------------------------------------
module sdff_datapath (
   input  logic                   clock,
   input  logic [3:0]             func,
   input  logic [15:0]            value,
   input  logic [3:0]             addr,
   input  logic [7:0]             data,
   input  sdff_pkg::dp_cmd_type   cmd,
   output sdff_pkg::dp_stat_type  stat,
   output logic [3:0]             wr_addr,
   output logic [7:0]             wr_byte
);

   logic [3:0]  func_ff;
   logic [15:0] value_ff;
   logic [3:0]  addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  shadow_ff [sdff_pkg::RAM_BYTES];
   logic [3:0]  dig_ff [3];
   logic [2:0]  dp_ff;
   logic        blank_ff;
   logic [3:0]  a_ff;
   logic [7:0]  b_ff;
   logic [9:0]  v10;
   logic [15:0] t2;
   logic [6:0]  r2;
   logic [14:0] t1;
   logic [3:0]  d2, d1, d0;

   // value already clamped below 1000: digits by multiply-and-shift with constant reciprocals
   always_comb begin
      v10 = value_ff[9:0];
      t2 = {6'd0, v10} * 16'd41;
      d2 = t2[15:12];
      r2 = 7'(v10 - 10'(d2) * 10'd100);
      t1 = {8'd0, r2} * 15'd205;
      d1 = t1[14:11];
      d0 = 4'(r2 - 7'(d1) * 7'd10);
   end

   // plan: clamp values on load (PM25 above 999 becomes 0 and sets blank)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func;
         addr_ff <= addr;
         data_ff <= data;
         blank_ff <= (value > 16'd999);
         unique case (func)
            sdff_pkg::FUNC_SPEED:  value_ff <= (value > 16'd3) ? 16'd3 : value;
            sdff_pkg::FUNC_TIMER:  value_ff <= (value > 16'd24) ? 16'd24 : value;
            sdff_pkg::FUNC_FILTER: value_ff <= (value > 16'd100) ? 16'd100 : value;
            sdff_pkg::FUNC_PM25:   value_ff <= (value > 16'd999) ? 16'd0 : value;
            default:               value_ff <= value;
         endcase
      end
      // value is held for the whole request, digits settle during planning
      dig_ff[2] <= d2;
      dig_ff[1] <= d1;
      dig_ff[0] <= d0;
   end

   always_comb begin
      stat = '0;
      unique case (func_ff)
         sdff_pkg::FUNC_INIT:   begin stat.nsteps = 5'd14; stat.has_pre = 1'b1; end
         sdff_pkg::FUNC_CLEAR,
         sdff_pkg::FUNC_ALLON:  stat.nsteps = 5'd14;
         sdff_pkg::FUNC_DIGON,
         sdff_pkg::FUNC_DEFLT,
         sdff_pkg::FUNC_AP:     stat.nsteps = 5'd12;
         sdff_pkg::FUNC_LEDS:   stat.nsteps = 5'd4;
         sdff_pkg::FUNC_SPEED:  stat.nsteps = 5'd2;
         sdff_pkg::FUNC_TIMER:  stat.nsteps = 5'd4;
         sdff_pkg::FUNC_PM25,
         sdff_pkg::FUNC_FILTER: stat.nsteps = 5'd6;
         sdff_pkg::FUNC_BRIGHT: stat.solo = 1'b1;
         sdff_pkg::FUNC_RAW:    stat.nsteps = 5'd1;
         default:               stat.none = 1'b1;
      endcase
   end

   // byte plan for one step: address, op and operand
   logic [3:0] p_addr;
   logic [7:0] p_arg;
   sdff_pkg::op_type p_op;
   logic [3:0] p_dig;
   logic       p_dp;
   logic       p_hi;
   logic [2:0] p_grid;
   logic [7:0] p_rd;
   logic [7:0] tens;

   always_comb begin
      p_addr = cmd.step[3:0];
      p_arg  = 8'h00;
      p_op   = sdff_pkg::OP_SET;
      p_dig  = 4'd0;
      p_dp   = 1'b1;
      p_hi   = cmd.step[0];
      p_grid = 3'd7;
      tens   = 8'h00;
      unique case (func_ff)
         sdff_pkg::FUNC_INIT, sdff_pkg::FUNC_CLEAR: p_arg = 8'h00;
         sdff_pkg::FUNC_ALLON: p_arg = 8'hFF;
         sdff_pkg::FUNC_DIGON, sdff_pkg::FUNC_DEFLT, sdff_pkg::FUNC_AP: begin
            p_grid = 3'(3'd7 - 3'(cmd.step[4:1]));
            p_dig  = (func_ff == sdff_pkg::FUNC_AP) ? 4'd1 : 4'd0;
         end
         sdff_pkg::FUNC_LEDS: begin
            p_op = sdff_pkg::OP_LED;
            p_arg = {7'd0, value_ff[cmd.step[1:0]]};
            unique case (cmd.step[1:0])
               2'd0: p_addr = 4'd2;
               2'd1: p_addr = 4'd0;
               2'd2: p_addr = 4'd4;
               default: p_addr = 4'd6;
            endcase
         end
         sdff_pkg::FUNC_SPEED: begin
            p_grid = 3'd4;
            p_dig = value_ff[3:0];
         end
         sdff_pkg::FUNC_TIMER: begin
            tens = (value_ff[7:0] >= 8'd20) ? 8'd2 : (value_ff[7:0] >= 8'd10) ? 8'd1 : 8'd0;
            p_grid = cmd.step[1] ? 3'd2 : 3'd3;
            p_dig = cmd.step[1] ? 4'(value_ff[7:0] - tens * 8'd10) : tens[3:0];
         end
         sdff_pkg::FUNC_PM25, sdff_pkg::FUNC_FILTER: begin
            p_grid = 3'(3'd7 - 3'(cmd.step[4:1]));
            p_dig = dig_ff[2'd2 - cmd.step[2:1]];
            p_dp = (func_ff == sdff_pkg::FUNC_PM25) || (cmd.step[4:1] == 4'd2);
         end
         sdff_pkg::FUNC_RAW: begin
            p_addr = addr_ff;
            p_arg = data_ff;
         end
         default: ;
      endcase
      if (func_ff inside {sdff_pkg::FUNC_DIGON, sdff_pkg::FUNC_DEFLT, sdff_pkg::FUNC_AP,
                          sdff_pkg::FUNC_SPEED, sdff_pkg::FUNC_TIMER, sdff_pkg::FUNC_PM25,
                          sdff_pkg::FUNC_FILTER}) begin
         p_addr = {3'(p_grid - 3'd1), p_hi};
         if (func_ff == sdff_pkg::FUNC_DIGON) begin
            p_op = sdff_pkg::OP_OR;
            p_arg = p_hi ? 8'h01 : 8'hFE;
         end else if (func_ff == sdff_pkg::FUNC_PM25 && blank_ff) begin
            p_op = sdff_pkg::OP_AND;
            p_arg = p_hi ? 8'hFE : 8'h01;
         end else if (p_hi) begin
            p_op = sdff_pkg::OP_LED;
            p_arg = (p_dig != 4'd1 && p_dig != 4'd4) ? 8'h01 : 8'h00;
         end else begin
            p_op = sdff_pkg::OP_LOW;
            p_arg = sdff_pkg::seg_low(p_dig) | (p_dp ? 8'h80 : 8'h00);
         end
      end
      p_rd = (p_addr < 4'(sdff_pkg::RAM_BYTES)) ? shadow_ff[p_addr] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff <= p_addr;
         case (p_op)
            sdff_pkg::OP_OR:  b_ff <= p_rd | p_arg;
            sdff_pkg::OP_AND: b_ff <= p_rd & p_arg;
            sdff_pkg::OP_LOW: b_ff <= (p_rd & 8'h01) | p_arg;
            sdff_pkg::OP_LED: b_ff <= (p_rd & 8'hFE) | p_arg;
            default:          b_ff <= p_arg;
         endcase
      end
      if (cmd.clear) begin
         for (int i = 0; i < sdff_pkg::RAM_BYTES; i++) shadow_ff[i] <= 8'h00;
      end else if (cmd.commit && a_ff < 4'(sdff_pkg::RAM_BYTES)) begin
         shadow_ff[a_ff] <= b_ff;
      end
   end

   assign wr_addr = a_ff;
   assign wr_byte = b_ff;

endmodule

[sv/sdff_ctrl.sv]
// ----------------------------------------------------------------------------
// sdff_ctrl
// sequencer: walks the byte writes of a request and issues frames
// ----------------------------------------------------------------------------
module sdff_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [15:0]           req_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_cmd,
   output logic                  out_has,
   output logic [7:0]            out_data,
   output logic                  out_last,
   input  sdff_pkg::dp_stat_type stat,
   output sdff_pkg::dp_cmd_type  cmd,
   input  logic [3:0]            wr_addr,
   input  logic [7:0]            wr_byte
);

   sdff_pkg::state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] pre_ff, pre_in;     // init: prefix frames then trailing on
   logic       post_ff, post_in;
   logic [7:0] bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdff_pkg::ST_IDLE;
         step_ff <= '0;
         pre_ff <= '0;
         post_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pre_ff <= pre_in;
         post_ff <= post_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         unique case (req_value)
            16'd0:   bright_ff <= 8'h88;
            16'd1:   bright_ff <= 8'h8B;
            16'd2:   bright_ff <= 8'h8F;
            default: bright_ff <= 8'h80;
         endcase
      end
   end

   logic last_step;
   assign last_step = (step_ff == 5'(stat.nsteps - 5'd1));

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      pre_in = pre_ff;
      post_in = post_ff;
      cmd = '0;
      cmd.step = step_ff;
      cmd.clear = reset;
      req_ready = 1'b0;
      out_valid = 1'b0;
      out_cmd = sdff_pkg::CMD_WRITE;
      out_has = 1'b0;
      out_data = 8'h00;
      out_last = 1'b0;
      unique case (state_ff)
         sdff_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in = '0;
               state_in = sdff_pkg::ST_PLAN;
            end
         end
         sdff_pkg::ST_PLAN: begin
            pre_in = stat.has_pre ? 2'd2 : 2'd0;
            post_in = stat.has_pre;
            if (stat.none) state_in = sdff_pkg::ST_IDLE;
            else if (stat.solo || stat.has_pre) state_in = sdff_pkg::ST_SOLO;
            else state_in = sdff_pkg::ST_READ;
         end
         sdff_pkg::ST_READ: begin
            cmd.prep = 1'b1;
            state_in = sdff_pkg::ST_CMD;
         end
         sdff_pkg::ST_CMD: begin
            out_valid = 1'b1;
            if (out_ready) state_in = sdff_pkg::ST_DATA;
         end
         sdff_pkg::ST_DATA: begin
            out_valid = 1'b1;
            out_cmd = sdff_pkg::CMD_ADDR + {4'd0, wr_addr};
            out_has = 1'b1;
            out_data = wr_byte;
            out_last = last_step && !post_ff;
            if (out_ready) begin
               cmd.commit = 1'b1;
               step_in = step_ff + 5'd1;
               if (!last_step) state_in = sdff_pkg::ST_READ;
               else if (post_ff) state_in = sdff_pkg::ST_SOLO;
               else state_in = sdff_pkg::ST_IDLE;
            end
         end
         sdff_pkg::ST_SOLO: begin
            out_valid = 1'b1;
            if (pre_ff == 2'd2) out_cmd = sdff_pkg::CMD_MODE;
            else if (pre_ff == 2'd1) out_cmd = sdff_pkg::CMD_AUTO;
            else if (post_ff) out_cmd = sdff_pkg::CMD_ON;
            else out_cmd = bright_ff;
            out_last = (pre_ff == 2'd0);
            if (out_ready) begin
               if (pre_ff != 2'd0) begin
                  pre_in = pre_ff - 2'd1;
                  if (pre_ff == 2'd1) state_in = sdff_pkg::ST_READ;
               end else begin
                  post_in = 1'b0;
                  state_in = sdff_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sdff_pkg::ST_IDLE;
      endcase
   end

endmodule

[verif/segment_display_frame_formatter_core_tb.sv]
// ----------------------------------------------------------------------------
// segment_display_frame_formatter_core_tb
// self-checking bench: directed table then random requests, each frame
// compared with a shadow-ram predictor under random source/sink idling
// ----------------------------------------------------------------------------
module segment_display_frame_formatter_core_tb;

   typedef struct packed {
      logic [7:0] cmd;
      logic       has_data;
      logic [7:0] dat;
      logic       last;
   } frame_type;

   typedef struct {
      logic [3:0]  func;
      logic [15:0] value;
      logic [3:0]  addr;
      logic [7:0]  data;
      int          nchk;      // typed-in frames to check, 0 = predictor only
      frame_type   chk [2];
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdff_req_if req ();
   sdff_rsp_if rsp ();

   segment_display_frame_formatter_core uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   logic [7:0] shadow [sdff_pkg::RAM_BYTES];
   frame_type  pending_frames [$];
   frame_type  typed_frames [$];
   frame_type  batch [$];
   int         mismatches = 0;
   int         frames_seen = 0;
   int         items_sent = 0;
   int         src_idle_pct = 0;
   int         snk_idle_pct = 0;
   int         hold_cycles = 0;

   function automatic logic [7:0] seg_pat(int d);
      case (d)
         0: return 8'h6E; 1: return 8'h60; 2: return 8'h56; 3: return 8'h72;
         4: return 8'h78; 5: return 8'h3A; 6: return 8'h3E; 7: return 8'h60;
         8: return 8'h7E; 9: return 8'h7A; default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] rd(int a);
      return (a < sdff_pkg::RAM_BYTES) ? shadow[a] : 8'h00;
   endfunction

   function automatic void solo(logic [7:0] c);
      batch.push_back('{c, 1'b0, 8'h00, 1'b0});
   endfunction

   function automatic void wr(int a, logic [7:0] d);
      a = a & 15;
      if (a < sdff_pkg::RAM_BYTES) shadow[a] = d;
      solo(sdff_pkg::CMD_WRITE);
      batch.push_back('{sdff_pkg::CMD_ADDR + 8'(a), 1'b1, d, 1'b0});
   endfunction

   function automatic void digit(int g, int d, bit dp);
      int la;
      logic [7:0] lo, hi;
      la = (g - 1) * 2;
      lo = (rd(la) & 8'h01) | seg_pat(d);
      if (dp) lo |= 8'h80;
      wr(la, lo);
      hi = rd(la + 1) & 8'hFE;
      if (d != 1 && d != 4) hi |= 8'h01;
      wr(la + 1, hi);
   endfunction

   function automatic void led(int a, bit on);
      wr(a, on ? (rd(a) | 8'h01) : (rd(a) & 8'hFE));
   endfunction

   // works out the frames of one request and advances the shadow
   function automatic void predict_frames(logic [3:0] f, logic [15:0] val,
                                          logic [3:0] a, logic [7:0] d);
      int v, la;
      batch.delete();
      case (f)
         sdff_pkg::FUNC_INIT: begin
            solo(sdff_pkg::CMD_MODE); solo(sdff_pkg::CMD_AUTO);
            for (int i = 0; i < 14; i++) wr(i, 8'h00);
            solo(sdff_pkg::CMD_ON);
         end
         sdff_pkg::FUNC_CLEAR: for (int i = 0; i < 14; i++) wr(i, 8'h00);
         sdff_pkg::FUNC_ALLON: for (int i = 0; i < 14; i++) wr(i, 8'hFF);
         sdff_pkg::FUNC_DIGON: for (int g = 7; g >= 2; g--) begin
            la = (g - 1) * 2;
            wr(la, rd(la) | 8'hFE);
            wr(la + 1, rd(la + 1) | 8'h01);
         end
         sdff_pkg::FUNC_DEFLT, sdff_pkg::FUNC_AP:
            for (int g = 7; g >= 2; g--)
               digit(g, (f == sdff_pkg::FUNC_DEFLT) ? 0 : 1, 1'b1);
         sdff_pkg::FUNC_LEDS: begin
            led(2, val[0]); led(0, val[1]); led(4, val[2]); led(6, val[3]);
         end
         sdff_pkg::FUNC_SPEED: begin
            v = (val > 3) ? 3 : val;
            digit(4, v, 1'b1);
         end
         sdff_pkg::FUNC_TIMER: begin
            v = (val > 24) ? 24 : val;
            digit(3, v / 10, 1'b1);
            digit(2, v % 10, 1'b1);
         end
         sdff_pkg::FUNC_PM25: begin
            v = val;
            if (v > 999) begin
               for (int g = 7; g >= 5; g--) begin
                  la = (g - 1) * 2;
                  wr(la, rd(la) & 8'h01);
                  wr(la + 1, rd(la + 1) & 8'hFE);
               end
            end else begin
               digit(7, v / 100, 1'b1);
               digit(6, (v / 10) % 10, 1'b1);
               digit(5, v % 10, 1'b1);
            end
         end
         sdff_pkg::FUNC_FILTER: begin
            v = (val > 100) ? 100 : val;
            digit(7, v / 100, 1'b0);
            digit(6, (v / 10) % 10, 1'b0);
            digit(5, v % 10, 1'b1);
         end
         sdff_pkg::FUNC_BRIGHT:
            solo(val == 0 ? 8'h88 : val == 1 ? 8'h8B : val == 2 ? sdff_pkg::CMD_ON : 8'h80);
         sdff_pkg::FUNC_RAW: wr(a, d);
         default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_frames.push_back(batch[i]);
   endfunction

   task automatic send_request(logic [3:0] f, logic [15:0] val,
                               logic [3:0] a, logic [7:0] d);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) @(negedge clock);
      req.valid <= 1'b1;
      req.func <= f; req.value <= val; req.addr <= a; req.data <= d;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_frames(f, val, a, d);
      items_sent++;
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_frames.size() > 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // receiver ready
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // frame checker
   always @(posedge clock) begin
      frame_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.frame_cmd, rsp.has_data, rsp.frame_data, rsp.last};
         frames_seen++;
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected frame %h", got);
         end else begin
            want = pending_frames.pop_front();
            if (typed_frames.size() > 0) begin
               if (typed_frames[0] !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("table/predictor disagree: table %h pred %h",
                              typed_frames[0], want);
               end
               void'(typed_frames.pop_front());
            end
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   row_type dir_tab [$];

   task automatic add_row(logic [3:0] f, logic [15:0] val, logic [3:0] a,
                          logic [7:0] d, int n = 0,
                          frame_type c0 = '0, frame_type c1 = '0);
      row_type r;
      r.func = f; r.value = val; r.addr = a; r.data = d; r.nchk = n;
      r.chk[0] = c0; r.chk[1] = c1;
      dir_tab.push_back(r);
   endtask

   initial begin
      int f, k;
      logic [15:0] v;
      req.valid = 1'b0; req.func = '0; req.value = '0; req.addr = '0; req.data = '0;
      foreach (shadow[i]) shadow[i] = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(sdff_pkg::FUNC_BRIGHT, 16'd0, 0, 0, 1, '{8'h88, 1'b0, 8'h00, 1'b1});
      add_row(sdff_pkg::FUNC_BRIGHT, 16'd1, 0, 0, 1, '{8'h8B, 1'b0, 8'h00, 1'b1});
      add_row(sdff_pkg::FUNC_BRIGHT, 16'd2, 0, 0, 1, '{8'h8F, 1'b0, 8'h00, 1'b1});
      add_row(sdff_pkg::FUNC_BRIGHT, 16'hFFFF, 0, 0, 1, '{8'h80, 1'b0, 8'h00, 1'b1});
      add_row(sdff_pkg::FUNC_RAW, 0, 4'd0, 8'hFF, 2, '{8'h44, 1'b0, 8'h00, 1'b0},
              '{8'hC0, 1'b1, 8'hFF, 1'b1});
      add_row(sdff_pkg::FUNC_RAW, 0, 4'd15, 8'hA5, 2, '{8'h44, 1'b0, 8'h00, 1'b0},
              '{8'hCF, 1'b1, 8'hA5, 1'b1});
      add_row(sdff_pkg::FUNC_RAW, 0, 4'd14, 8'h00, 0);
      add_row(sdff_pkg::FUNC_INIT, 0, 0, 0);
      add_row(sdff_pkg::FUNC_ALLON, 0, 0, 0);
      add_row(sdff_pkg::FUNC_DEFLT, 0, 0, 0);
      add_row(sdff_pkg::FUNC_CLEAR, 0, 0, 0);
      add_row(sdff_pkg::FUNC_DIGON, 0, 0, 0);
      add_row(sdff_pkg::FUNC_AP, 0, 0, 0);
      add_row(sdff_pkg::FUNC_LEDS, 16'hFFFF, 0, 0);
      add_row(sdff_pkg::FUNC_LEDS, 16'h0005, 0, 0);
      add_row(sdff_pkg::FUNC_SPEED, 16'hFFFF, 0, 0);
      add_row(sdff_pkg::FUNC_SPEED, 16'd1, 0, 0);
      add_row(sdff_pkg::FUNC_TIMER, 16'd24, 0, 0);
      add_row(sdff_pkg::FUNC_TIMER, 16'hFFFF, 0, 0);
      add_row(sdff_pkg::FUNC_PM25, 16'd999, 0, 0);
      add_row(sdff_pkg::FUNC_PM25, 16'd1000, 0, 0);
      add_row(sdff_pkg::FUNC_FILTER, 16'd100, 0, 0);
      add_row(sdff_pkg::FUNC_FILTER, 16'hFFFF, 0, 0);
      add_row(4'd13, 0, 0, 0);
      add_row(4'd15, 16'hFFFF, 4'd15, 8'hFF);

      src_idle_pct = 16; snk_idle_pct = 84;
      foreach (dir_tab[i]) begin
         for (int j = 0; j < dir_tab[i].nchk; j++) typed_frames.push_back(dir_tab[i].chk[j]);
         send_request(dir_tab[i].func, dir_tab[i].value, dir_tab[i].addr, dir_tab[i].data);
         drain();   // keep typed rows aligned with their frames
      end
      typed_frames.delete();

      // long receiver hold-off while requests keep coming
      hold_cycles = 400;
      for (k = 0; k < 480; k++) begin
         if (k == 160) begin src_idle_pct = 84; snk_idle_pct = 16; end
         if (k == 320) begin src_idle_pct = 0; snk_idle_pct = 0; end
         f = $urandom_range(99) < 95 ? $urandom_range(12) : $urandom_range(15, 13);
         case ($urandom_range(3))
            0: v = 16'($urandom_range(30));
            1: v = 16'($urandom_range(1100));
            2: v = 16'($urandom_range(3));
            default: v = 16'($urandom);
         endcase
         send_request(4'(f), v, 4'($urandom_range(15)), 8'($urandom));
      end
      drain();

      $display("covered %0d requests (all func codes, clamps, blanking, raw out of range)",
               items_sent);
      $display("checked %0d frames, %0d mismatches, %0d left over",
               frames_seen, mismatches, pending_frames.size());
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("** segment_display_frame_formatter_core: PASSED **");
      end else begin
         $display("** segment_display_frame_formatter_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("** segment_display_frame_formatter_core: FAILED **");
      $finish;
   end

endmodule
